// ===== hw/rtl/jsu_pkg.sv =====
package jsu_pkg;

    localparam int MAX_OUT = 6;
    localparam int CNT_W   = $clog2(MAX_OUT + 1);
    localparam int HEX_LEN = 4;
    localparam int HOLD_N  = HEX_LEN - 1;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_BS    = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] ASCII_LIMIT = 8'd128;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ESC   = 2'd1,
        PH_HEX   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic       out_run_end;
    } out_item_t;

    // All bytes one request produces, oldest in entry zero
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] bytes;
        logic [CNT_W-1:0]        cnt;
        logic                    last;
    } run_t;

endpackage

// ===== hw/rtl/jsu_front.sv =====
module jsu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  jsu_pkg::in_item_t item,
    input  logic            q_full,
    output logic            q_wr,
    output jsu_pkg::run_t   q_data
);
    import jsu_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [1:0]              count_reg, count_next;
    logic [HOLD_N-1:0][7:0]  hold_reg;
    logic [HOLD_N-1:0][7:0]  tail_bytes;
    logic                    hold_we;
    logic                    accept;
    run_t                    run;

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            "b":     r = 8'h08;
            "f":     r = 8'h0C;
            "n":     r = 8'h0A;
            "r":     r = 8'h0D;
            "t":     r = 8'h09;
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        if (c >= "0" && c <= "9")
            d = c - "0";
        else if (c >= "a" && c <= "f")
            d = c - "a" + 8'd10;
        else
            d = c - "A" + 8'd10;
        return d[3:0];
    endfunction

    function automatic run_t append(input run_t r, input logic [7:0] b);
        run_t o;
        o = r;
        o.bytes[r.cnt] = b;
        o.cnt = r.cnt + 1'b1;
        return o;
    endfunction

    // strtol-style read of the four hex bytes
    function automatic run_t decode_hex4(input logic [HEX_LEN-1:0][7:0] h);
        run_t        r;
        logic [2:0]  p;
        logic        skip;
        logic        neg;
        logic        run_on;
        logic [15:0] v;
        logic [2:0]  digits;
        r      = '0;
        p      = '0;
        skip   = 1'b1;
        neg    = 1'b0;
        run_on = 1'b1;
        v      = '0;
        digits = '0;
        for (int i = 0; i < HEX_LEN; i++) begin
            if (skip && is_ws(h[i]))
                p = 3'(i + 1);
            else
                skip = 1'b0;
        end
        if (p < 3'(HEX_LEN) && (h[p[1:0]] == "+" || h[p[1:0]] == "-")) begin
            neg = (h[p[1:0]] == "-");
            p   = p + 3'd1;
        end
        // take the 0x prefix only when a hex digit follows inside the group
        if (p <= 3'd1 && h[p[1:0]] == "0" && (h[p[1:0] + 2'd1] | 8'h20) == "x"
                && is_hex(h[p[1:0] + 2'd2]))
            p = p + 3'd2;
        for (int i = 0; i < HEX_LEN; i++) begin
            if (3'(i) >= p && run_on) begin
                if (is_hex(h[i])) begin
                    v      = {v[11:0], hex_val(h[i])};
                    digits = digits + 3'd1;
                end
                else begin
                    run_on = 1'b0;
                end
            end
        end
        if (digits == 3'd0) begin
            r = append(r, CH_BS);
            r = append(r, CH_U);
            for (int i = 0; i < HEX_LEN; i++)
                r = append(r, h[i]);
        end
        else if (neg) begin
            r = append(r, 8'(~v[7:0] + 8'd1));
        end
        else begin
            r = append(r, (v < 16'(ASCII_LIMIT)) ? v[7:0] : CH_QMARK);
        end
        return r;
    endfunction

    // String ended inside the hex group: backslash, u, then the held bytes as a tail
    function automatic run_t decode_tail(input logic [HOLD_N-1:0][7:0] t,
                                         input logic [1:0] n);
        run_t r;
        r = '0;
        r = append(r, CH_BS);
        r = append(r, CH_U);
        if (t[0] == CH_BS && n >= 2'd2) begin
            if (t[1] == CH_U) begin
                r = append(r, CH_BS);
                r = append(r, CH_U);
            end
            else begin
                r = append(r, map_escape(t[1]));
            end
            if (n == 2'd3)
                r = append(r, t[2]);
        end
        else begin
            r = append(r, t[0]);
            if (t[1] == CH_BS && n == 2'd3) begin
                if (t[2] == CH_U) begin
                    r = append(r, CH_BS);
                    r = append(r, CH_U);
                end
                else begin
                    r = append(r, map_escape(t[2]));
                end
            end
            else if (n >= 2'd2) begin
                r = append(r, t[1]);
                if (n == 2'd3)
                    r = append(r, t[2]);
            end
        end
        return r;
    endfunction

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        for (int i = 0; i < HOLD_N; i++)
            tail_bytes[i] = (2'(i) == count_reg) ? item.in_byte : hold_reg[i];
    end

    always_comb
    begin
        run        = '0;
        phase_next = phase_reg;
        count_next = count_reg;
        hold_we    = 1'b0;
        unique case (phase_reg)
            PH_ESC:
            begin
                if (item.in_byte == CH_U) begin
                    if (item.in_last) begin
                        run = append(run, CH_BS);
                        run = append(run, CH_U);
                    end
                    else begin
                        phase_next = PH_HEX;
                        count_next = '0;
                    end
                end
                else begin
                    run        = append(run, map_escape(item.in_byte));
                    phase_next = PH_PLAIN;
                end
            end
            PH_HEX:
            begin
                if (count_reg == 2'(HOLD_N)) begin
                    run        = decode_hex4({item.in_byte, hold_reg[2], hold_reg[1],
                                              hold_reg[0]});
                    phase_next = PH_PLAIN;
                    count_next = '0;
                end
                else begin
                    hold_we    = 1'b1;
                    count_next = count_reg + 2'd1;
                    if (item.in_last)
                        run = decode_tail(tail_bytes, count_reg + 2'd1);
                end
            end
            default:
            begin
                phase_next = PH_PLAIN;
                if (item.in_byte == CH_BS && !item.in_last)
                    phase_next = PH_ESC;
                else
                    run = append(run, item.in_byte);
            end
        endcase
        if (item.in_last) begin
            phase_next = PH_PLAIN;
            count_next = '0;
        end
        run.last = item.in_last;
    end

    assign q_wr   = accept && (run.cnt != '0);
    assign q_data = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_PLAIN;
            count_reg <= '0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_we)
            hold_reg[count_reg] <= item.in_byte;
    end

endmodule

// ===== hw/rtl/jsu_queue.sv =====
module jsu_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  jsu_pkg::run_t wr_data,
    output logic          full,
    input  logic          rd,
    output jsu_pkg::run_t rd_data,
    output logic          empty
);
    import jsu_pkg::*;

    run_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hw/rtl/jsu_back.sv =====
module jsu_back (
    input  logic               clk,
    input  logic               rst_n,
    input  jsu_pkg::run_t      head,
    input  logic               q_empty,
    output logic               q_rd,
    input  logic               pop,
    output logic               empty,
    output jsu_pkg::out_item_t result
);
    import jsu_pkg::*;

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             at_end;
    logic             take;

    assign at_end = (idx_reg == head.cnt - 1'b1);
    assign take   = pop && !q_empty;
    assign empty  = q_empty;
    assign q_rd   = take && at_end;

    assign result.out_byte    = head.bytes[idx_reg];
    assign result.out_run_end = at_end;
    assign result.out_last    = head.last && at_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (take)
            idx_next = at_end ? '0 : idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

// ===== hw/rtl/json_string_unescaper_top.sv =====
// Channel   Direction  Handshake                  Payload
// input     in         push / full                item   (in_byte, in_last)
// result    out        empty / pop                result (out_byte, out_last, out_run_end)
//
// One input byte is taken per cycle while the run queue has room; its decoded bytes
// (zero to six) land in the queue in the same cycle and drain one per cycle on pop.
// A request that yields k bytes occupies the result side for k pops, so an escape
// burst slows input only once the four-entry run queue fills.
// Reset clears escape phase, hex count and the queue; held hex bytes need no reset.
module json_string_unescaper_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  jsu_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output jsu_pkg::out_item_t result
);
    import jsu_pkg::*;

    run_t q_wr_data;
    run_t q_head;
    logic q_wr, q_full, q_rd, q_empty;

    jsu_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_data (q_wr_data)
    );

    jsu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    jsu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // A queued run always carries at least one byte and never more than six
    assert property (@(posedge clk) disable iff (!rst_n)
        q_wr |-> (q_wr_data.cnt != '0 && q_wr_data.cnt <= CNT_W'(MAX_OUT)))
        else $error("run pushed with bad byte count");

    assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (q_head.cnt != '0))
        else $error("queue head holds an empty run");

    // The final byte of a string always closes its request's run
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.out_last) |-> result.out_run_end)
        else $error("out_last without out_run_end");

    // A run leaves the queue only on its last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> (pop && result.out_run_end))
        else $error("run dropped before its last byte");

endmodule
